// ----- src/aoac_pkg.sv -----
// ---------------------------------------------------------------------------
// aoac_pkg: shared types and constants for the box overlap and axis clip block
// Request, response and queue entry structs, plus the axis codes.
// ---------------------------------------------------------------------------
package aoac_pkg;

   localparam int WORD_BITS        = 32;
   localparam int SPAN_BITS        = 64;
   localparam int COORD_BITS_DEF   = 32;
   localparam int QUEUE_DEPTH_DEF  = 2;

   // axis codes carried in op
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic [1:0]                  op;
      logic [SPAN_BITS-1:0]        a_x_span;
      logic [SPAN_BITS-1:0]        a_y_span;
      logic [SPAN_BITS-1:0]        a_z_span;
      logic [SPAN_BITS-1:0]        b_x_span;
      logic [SPAN_BITS-1:0]        b_y_span;
      logic [SPAN_BITS-1:0]        b_z_span;
      logic signed [WORD_BITS-1:0] move_request;
   } req_type;

   typedef struct packed {
      logic                        boxes_overlap;
      logic signed [WORD_BITS-1:0] move_allowed;
   } rsp_type;

   // classified request, handed from the front end to the back end
   typedef struct packed {
      logic                        overlap_all;
      logic                        overlap_others;
      logic                        a_above_b;     // a.lo >= b.hi on the move axis
      logic                        a_below_b;     // a.hi <= b.lo on the move axis
      logic signed [WORD_BITS-1:0] a_lo;
      logic signed [WORD_BITS-1:0] a_hi;
      logic signed [WORD_BITS-1:0] b_lo;
      logic signed [WORD_BITS-1:0] b_hi;
      logic signed [WORD_BITS-1:0] move;
   } task_type;

endpackage

// ----- src/aoac_front.sv -----
// ---------------------------------------------------------------------------
// aoac_front: request intake and classification
// Unpacks the spans, runs the open-interval overlap tests on all three axes,
// picks out the move axis and registers one classified entry per request.
// ---------------------------------------------------------------------------
module aoac_front #(
   parameter int COORD_BITS = aoac_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  aoac_pkg::req_type req_data,
   output logic              task_valid,
   output aoac_pkg::task_type task_data
);
   import aoac_pkg::*;

   // sign-extend the low COORD_BITS of a word to the full word width
   function automatic logic signed [WORD_BITS-1:0] coord_of(input logic [WORD_BITS-1:0] w);
      logic signed [COORD_BITS-1:0] c;
      c = signed'(w[COORD_BITS-1:0]);
      return WORD_BITS'(c);
   endfunction

   logic signed [WORD_BITS-1:0] a_lo [3];
   logic signed [WORD_BITS-1:0] a_hi [3];
   logic signed [WORD_BITS-1:0] b_lo [3];
   logic signed [WORD_BITS-1:0] b_hi [3];
   logic [2:0]                  ov;
   logic [2:0]                  axis_hot;
   logic [1:0]                  axis;
   logic                        valid_ff, valid_in;
   task_type                    entry_ff, entry_in;

   // unpack spans and test overlap per axis
   always_comb begin
      a_lo[0] = coord_of(req_data.a_x_span[SPAN_BITS-1:WORD_BITS]);
      a_hi[0] = coord_of(req_data.a_x_span[WORD_BITS-1:0]);
      a_lo[1] = coord_of(req_data.a_y_span[SPAN_BITS-1:WORD_BITS]);
      a_hi[1] = coord_of(req_data.a_y_span[WORD_BITS-1:0]);
      a_lo[2] = coord_of(req_data.a_z_span[SPAN_BITS-1:WORD_BITS]);
      a_hi[2] = coord_of(req_data.a_z_span[WORD_BITS-1:0]);
      b_lo[0] = coord_of(req_data.b_x_span[SPAN_BITS-1:WORD_BITS]);
      b_hi[0] = coord_of(req_data.b_x_span[WORD_BITS-1:0]);
      b_lo[1] = coord_of(req_data.b_y_span[SPAN_BITS-1:WORD_BITS]);
      b_hi[1] = coord_of(req_data.b_y_span[WORD_BITS-1:0]);
      b_lo[2] = coord_of(req_data.b_z_span[SPAN_BITS-1:WORD_BITS]);
      b_hi[2] = coord_of(req_data.b_z_span[WORD_BITS-1:0]);
      for (int i = 0; i < 3; i++) begin
         ov[i] = (a_lo[i] < b_hi[i]) && (b_lo[i] < a_hi[i]);
      end
   end

   // decode the axis; the unused code acts as z
   always_comb begin
      case (req_data.op)
         AXIS_X:  begin axis = 2'd0; axis_hot = 3'b001; end
         AXIS_Y:  begin axis = 2'd1; axis_hot = 3'b010; end
         AXIS_Z:  begin axis = 2'd2; axis_hot = 3'b100; end
         default: begin axis = 2'd2; axis_hot = 3'b100; end
      endcase
   end

   // build the classified entry
   always_comb begin
      entry_in.overlap_all    = &ov;
      entry_in.overlap_others = &(ov | axis_hot);
      entry_in.a_lo           = a_lo[axis];
      entry_in.a_hi           = a_hi[axis];
      entry_in.b_lo           = b_lo[axis];
      entry_in.b_hi           = b_hi[axis];
      entry_in.a_above_b      = a_lo[axis] >= b_hi[axis];
      entry_in.a_below_b      = a_hi[axis] <= b_lo[axis];
      entry_in.move           = req_data.move_request;
      valid_in                = take;
   end

   // hold the entry in a register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign task_valid = valid_ff;
   assign task_data  = entry_ff;

endmodule

// ----- src/aoac_queue.sv -----
// ---------------------------------------------------------------------------
// aoac_queue: small FIFO between front end and back end
// Holds classified requests; reports full so the front end can stop intake.
// ---------------------------------------------------------------------------
module aoac_queue #(
   parameter int DEPTH = aoac_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  aoac_pkg::task_type push_data,
   input  logic               pop,
   output logic               not_empty,
   output logic               full,
   output aoac_pkg::task_type pop_data
);
   import aoac_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   task_type              store_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign do_pop  = pop && (count_ff != '0);
   assign do_push = push && ((count_ff != CNT_BITS'(DEPTH)) || do_pop);

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write the entry store
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = count_ff != '0;
   assign full      = count_ff == CNT_BITS'(DEPTH);
   assign pop_data  = store_ff[rd_ptr_ff];

endmodule

// ----- src/aoac_back.sv -----
// ---------------------------------------------------------------------------
// aoac_back: move clip execution
// Computes the gap along the move axis, clips the move to it and registers
// the response with a one-cycle strobe.
// ---------------------------------------------------------------------------
module aoac_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               stuck_mode,
   input  logic               task_valid,
   input  aoac_pkg::task_type task_data,
   output logic               rsp_valid,
   output aoac_pkg::rsp_type  rsp_data
);
   import aoac_pkg::*;

   localparam int GAP_BITS = WORD_BITS + 1;

   logic signed [GAP_BITS-1:0]  gap_neg, gap_pos, move_ext;
   logic signed [WORD_BITS-1:0] result;
   logic                        valid_ff, valid_in;
   rsp_type                     rsp_ff, rsp_in;

   // pick the move: pass, clip to gap, or stop (in stuck mode)
   always_comb begin
      move_ext = GAP_BITS'(task_data.move);
      gap_neg  = GAP_BITS'(task_data.b_hi) - GAP_BITS'(task_data.a_lo);
      gap_pos  = GAP_BITS'(task_data.b_lo) - GAP_BITS'(task_data.a_hi);
      if (!task_data.overlap_others) begin
         result = task_data.move;
      end else if (task_data.a_above_b && task_data.move < 0) begin
         result = (gap_neg < move_ext) ? task_data.move : WORD_BITS'(gap_neg);
      end else if (task_data.a_below_b && task_data.move > 0) begin
         result = (gap_pos > move_ext) ? task_data.move : WORD_BITS'(gap_pos);
      end else begin
         result = stuck_mode ? '0 : task_data.move;
      end
      rsp_in.boxes_overlap = task_data.overlap_all;
      rsp_in.move_allowed  = result;
      valid_in             = task_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/aabb_overlap_and_axis_clip.sv -----
// ---------------------------------------------------------------------------
// aabb_overlap_and_axis_clip: box overlap test and axis move clip
// Front end classifies box pairs, a short queue decouples it from the back
// end, which clips the requested move and emits one response per request.
// ---------------------------------------------------------------------------
// A request is taken on any cycle where start is high and busy is low; busy
// stays low in normal use, so one request per cycle is accepted. Each
// response appears on rsp_data for one cycle with rsp_valid high, after passing
// the front register, the queue and the back register, in
// request order. The response cannot be stalled: the receiver must take it
// on the strobe. Write csr_wdata with csr_we only while no request is in
// flight; bit 0 selects stuck mode.
module aabb_overlap_and_axis_clip #(
   parameter int COORD_BITS  = aoac_pkg::COORD_BITS_DEF,
   parameter int QUEUE_DEPTH = aoac_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  aoac_pkg::req_type req_data,
   output logic              rsp_valid,
   output aoac_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_wdata
);
   import aoac_pkg::*;

   logic     stuck_mode_ff, stuck_mode_in;
   logic     front_valid, queue_not_empty, queue_full;
   task_type front_task, queue_task;

   // hold the stuck mode register
   assign stuck_mode_in = csr_we ? csr_wdata : stuck_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stuck_mode_ff <= 1'b0;
      end else begin
         stuck_mode_ff <= stuck_mode_in;
      end
   end

   assign busy = queue_full;

   aoac_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (start && !busy),
      .req_data   (req_data),
      .task_valid (front_valid),
      .task_data  (front_task)
   );

   aoac_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_task),
      .pop       (queue_not_empty),
      .not_empty (queue_not_empty),
      .full      (queue_full),
      .pop_data  (queue_task)
   );

   aoac_back u_back (
      .clock      (clock),
      .reset      (reset),
      .stuck_mode (stuck_mode_ff),
      .task_valid (queue_not_empty),
      .task_data  (queue_task),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the box overlap and axis clip block
// Drives box pairs and moves through the request port, predicts the overlap
// flag and clipped move for each accepted request, and compares every
// response strobe against the oldest prediction. Stuck mode is toggled
// between phases while nothing is in flight.
// ---------------------------------------------------------------------------
module tb_top;
   import aoac_pkg::*;

   localparam int          LATENCY      = 3;
   localparam int          LIMIT_CYCLES = 60000;
   localparam int          PHASES       = 5;
   localparam int          PHASE_ITEMS  = 350;
   localparam logic [1:0]  AXIS_Z_ALIAS = 2'd3;   // unused code, acts as z
   localparam logic [31:0] U1           = 32'h0001_0000;
   localparam logic [31:0] MIN_C        = 32'h8000_0000;
   localparam logic [31:0] MAX_C        = 32'h7FFF_FFFF;
   localparam logic [63:0] UNIT_SPAN    = {32'h0, U1};

   // ------------------------------------------------------------------------
   // Expected-response store and clip predictor
   // ------------------------------------------------------------------------
   class clip_scoreboard;
      rsp_type     pending_clips[$];
      bit          stuck_mode;
      int unsigned mismatches;

      static function int axis_index(logic [1:0] op);
         return (op == AXIS_X) ? 0 : (op == AXIS_Y) ? 1 : 2;
      endfunction

      // keep the low COORD_BITS bits and sign-extend them
      static function longint coord_of_word(logic [31:0] w);
         longint unsigned mask, sign, v;
         mask = (64'd1 << COORD_BITS_DEF) - 64'd1;
         sign = 64'd1 << (COORD_BITS_DEF - 1);
         v    = {32'd0, w} & mask;
         return longint'(v ^ sign) - longint'(sign);
      endfunction

      static function rsp_type clip_move(req_type r, bit stuck);
         logic [63:0] a_sp[3], b_sp[3];
         longint      alo[3], ahi[3], blo[3], bhi[3];
         bit          ov[3];
         int          ax, o1, o2;
         longint      mv, res;
         rsp_type     p;
         a_sp[0] = r.a_x_span; a_sp[1] = r.a_y_span; a_sp[2] = r.a_z_span;
         b_sp[0] = r.b_x_span; b_sp[1] = r.b_y_span; b_sp[2] = r.b_z_span;
         for (int i = 0; i < 3; i++) begin
            alo[i] = coord_of_word(a_sp[i][63:32]);
            ahi[i] = coord_of_word(a_sp[i][31:0]);
            blo[i] = coord_of_word(b_sp[i][63:32]);
            bhi[i] = coord_of_word(b_sp[i][31:0]);
            ov[i]  = (alo[i] < bhi[i]) && (blo[i] < ahi[i]);
         end
         ax = axis_index(r.op);
         o1 = (ax + 1) % 3;
         o2 = (ax + 2) % 3;
         mv = longint'($signed(r.move_request));
         // free move unless the boxes share the two cross axes
         if (!(ov[o1] && ov[o2])) begin
            res = mv;
         end else if (alo[ax] >= bhi[ax] && mv < 0) begin
            res = bhi[ax] - alo[ax];
            if (res < mv) res = mv;
         end else if (ahi[ax] <= blo[ax] && mv > 0) begin
            res = blo[ax] - ahi[ax];
            if (res > mv) res = mv;
         end else begin
            res = stuck ? 64'sd0 : mv;
         end
         p.boxes_overlap = ov[0] && ov[1] && ov[2];
         p.move_allowed  = res[31:0];
         return p;
      endfunction

      function void note_request(req_type r);
         pending_clips.push_back(clip_move(r, stuck_mode));
      endfunction

      task report_mismatch(string msg);
         if (mismatches < 40) $display("mismatch at %0t ns: %s", $time, msg);
         mismatches++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_clips.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         want = pending_clips.pop_front();
         if (got.boxes_overlap !== want.boxes_overlap)
            report_mismatch($sformatf("boxes_overlap got %b want %b",
                                      got.boxes_overlap, want.boxes_overlap));
         if (got.move_allowed !== want.move_allowed)
            report_mismatch($sformatf("move_allowed got %h want %h",
                                      got.move_allowed, want.move_allowed));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we;
   logic    csr_wdata;

   clip_scoreboard sb = new();
   int             idle_pct = 25;
   int unsigned    cycles = 0;

   aabb_overlap_and_axis_clip dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [63:0] mk_span(logic [31:0] lo, logic [31:0] hi);
      return {lo, hi};
   endfunction

   // coordinates on a quarter-unit grid, sometimes with fraction bits
   function automatic logic [31:0] rand_grid_coord();
      logic [31:0] c;
      c = ($urandom_range(64) - 32) * 32'h4000;
      if ($urandom_range(3) == 0) c = c + $urandom_range(16'h3FFF);
      return c;
   endfunction

   // build one axis of A and B in a chosen relation: overlap, touch, gap...
   function automatic void make_span_pair(input bit want_overlap,
                                          output logic [63:0] a,
                                          output logic [63:0] b);
      logic [31:0] lo, hi, w, w2, gap;
      int          pick;
      lo   = rand_grid_coord();
      w    = $urandom_range(8) * 32'h4000;
      w2   = $urandom_range(1, 8) * 32'h4000;
      gap  = $urandom_range(1, 8) * 32'h4000;
      hi   = lo + w;
      b    = {lo, hi};
      pick = want_overlap ? (($urandom_range(2) == 0) ? 0 : 7) : $urandom_range(7);
      case (pick)
         0: a = b;
         1: a = {hi, hi + w2};
         2: a = {lo - w2, lo};
         3: a = {hi + gap, hi + gap + w2};
         4: a = {lo - gap - w2, lo - gap};
         5: a = {hi, lo};
         6: a = {$urandom, $urandom};
         default: a = {lo + (w >> 1) - w2, lo + (w >> 1) + w2};
      endcase
   endfunction

   function automatic logic [31:0] rand_move();
      case ($urandom_range(9))
         0: return 32'h0;
         1: begin
            case ($urandom_range(3))
               0: return MIN_C;
               1: return MAX_C;
               2: return 32'h1;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         2: return $urandom;
         default: return ($urandom_range(64) - 32) * 32'h2000 + $urandom_range(16'h1FFF);
      endcase
   endfunction

   function automatic req_type rand_request();
      req_type     r;
      logic [63:0] a[3], b[3];
      int          axis_i;
      bit          noise;
      r.op   = 2'($urandom_range(3));
      axis_i = clip_scoreboard::axis_index(r.op);
      noise  = ($urandom_range(19) == 0);
      for (int i = 0; i < 3; i++) begin
         if (noise) begin
            a[i] = {$urandom, $urandom};
            b[i] = {$urandom, $urandom};
         end else begin
            make_span_pair(i != axis_i && $urandom_range(3) != 0, a[i], b[i]);
         end
      end
      r.a_x_span = a[0]; r.a_y_span = a[1]; r.a_z_span = a[2];
      r.b_x_span = b[0]; r.b_y_span = b[1]; r.b_z_span = b[2];
      r.move_request = rand_move();
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Driver tasks
   // ------------------------------------------------------------------------
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   task automatic send_box_pair(input logic [1:0] op,
                                input logic [63:0] ax, input logic [63:0] ay,
                                input logic [63:0] az, input logic [63:0] bx,
                                input logic [63:0] by, input logic [63:0] bz,
                                input logic [31:0] mv);
      req_type r;
      r.op = op;
      r.a_x_span = ax; r.a_y_span = ay; r.a_z_span = az;
      r.b_x_span = bx; r.b_y_span = by; r.b_z_span = bz;
      r.move_request = mv;
      send_request(r);
   endtask

   // hold the sender until every expected response is back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_clips.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_stuck_mode(input bit v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      sb.stuck_mode = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Response monitor and run limit
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_stuck_mode(1'b0);

      // directed: unit cube A against shifted B
      idle_pct = 0;
      send_box_pair(AXIS_X, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    UNIT_SPAN, UNIT_SPAN, UNIT_SPAN, U1);
      send_box_pair(AXIS_X, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    mk_span(U1, 2*U1), UNIT_SPAN, UNIT_SPAN, 3*U1);
      send_box_pair(AXIS_X, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    mk_span(3*U1, 4*U1), UNIT_SPAN, UNIT_SPAN, U1);
      send_box_pair(AXIS_X, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    mk_span(3*U1, 4*U1), UNIT_SPAN, UNIT_SPAN, 5*U1);
      send_box_pair(AXIS_X, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    mk_span(-4*U1, -2*U1), UNIT_SPAN, UNIT_SPAN, -5*U1);
      send_box_pair(AXIS_X, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    mk_span(-4*U1, -2*U1), UNIT_SPAN, UNIT_SPAN, U1);
      // cross axis apart: move passes unclipped; then clips along y, z and the z alias
      send_box_pair(AXIS_X, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    mk_span(3*U1, 4*U1), mk_span(5*U1, 6*U1), UNIT_SPAN, 5*U1);
      send_box_pair(AXIS_Y, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    UNIT_SPAN, mk_span(3*U1, 4*U1), UNIT_SPAN, 5*U1);
      send_box_pair(AXIS_Z, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    UNIT_SPAN, UNIT_SPAN, mk_span(-4*U1, -2*U1), -5*U1);
      send_box_pair(AXIS_Z_ALIAS, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    UNIT_SPAN, UNIT_SPAN, mk_span(3*U1, 4*U1), 5*U1);
      // zero move, touching and overlapping
      send_box_pair(AXIS_X, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    mk_span(U1, 2*U1), UNIT_SPAN, UNIT_SPAN, 32'h0);
      send_box_pair(AXIS_Y, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    UNIT_SPAN, UNIT_SPAN, UNIT_SPAN, 32'h0);
      // inverted spans on A and on B
      send_box_pair(AXIS_X, mk_span(2*U1, -2*U1), UNIT_SPAN, UNIT_SPAN,
                    UNIT_SPAN, UNIT_SPAN, UNIT_SPAN, -3*U1);
      send_box_pair(AXIS_Y, UNIT_SPAN, UNIT_SPAN, UNIT_SPAN,
                    mk_span(U1, 32'h0), UNIT_SPAN, UNIT_SPAN, -U1);
      // coordinate and move extremes
      send_box_pair(AXIS_X, mk_span(MAX_C, MAX_C), UNIT_SPAN, UNIT_SPAN,
                    mk_span(MIN_C, MIN_C), UNIT_SPAN, UNIT_SPAN, MIN_C);
      send_box_pair(AXIS_X, mk_span(MIN_C, MIN_C), UNIT_SPAN, UNIT_SPAN,
                    mk_span(MAX_C, MAX_C), UNIT_SPAN, UNIT_SPAN, MAX_C);
      send_box_pair(AXIS_Z, mk_span(MIN_C, MAX_C), mk_span(MIN_C, MAX_C),
                    mk_span(MIN_C, MAX_C), mk_span(MIN_C, MAX_C),
                    mk_span(MIN_C, MAX_C), mk_span(MIN_C, MAX_C), MAX_C);
      send_box_pair(AXIS_Y, '1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF);
      send_box_pair(AXIS_X, '0, '0, '0, '0, '0, '0, 32'h0);
      send_box_pair(AXIS_Y, UNIT_SPAN, mk_span(U1 >> 1, 3*(U1 >> 1)), UNIT_SPAN,
                    UNIT_SPAN, UNIT_SPAN, UNIT_SPAN, -U1);
      drain();

      // random phases, alternating stuck mode; one phase runs with no idling
      for (int p = 0; p < PHASES; p++) begin
         write_stuck_mode(p % 2 == 0);
         idle_pct = (p == 2) ? 0 : 25;
         for (int n = 0; n < PHASE_ITEMS; n++) send_request(rand_request());
         drain();
      end

      if (sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- aabb_overlap_and_axis_clip.f -----
src/aoac_pkg.sv
src/aoac_front.sv
src/aoac_queue.sv
src/aoac_back.sv
src/aabb_overlap_and_axis_clip.sv
tb/tb_top.sv
